// ===== design/dprc_pkg.sv =====
// Shared types and constants for the drift PI resample controller.
`default_nettype none
package dprc_pkg;

  localparam int DEV_W     = 3;
  localparam int DEV_IDX_W = 6;
  localparam int DRIFT_W   = 24;
  localparam int INTEG_W   = 24;
  localparam int DELAY_W   = 12;
  localparam int RATIO_W   = 31;
  localparam int SUM_W     = 50;
  localparam int CORR_W    = 34;
  localparam int FRAMES_W  = 19;
  localparam int ND_W      = 21;

  localparam logic signed [INTEG_W:0]  INTEG_LIMIT     = 25'sd8000000;
  localparam logic signed [INTEG_W:0]  INTEG_LIMIT_NEG = -25'sd8000000;
  localparam logic signed [CORR_W-1:0] CORR_MAX        = 34'sd10737418;
  localparam logic signed [CORR_W-1:0] CORR_MIN        = -34'sd10737419;
  localparam logic signed [CORR_W-1:0] WINDUP_POS      = 34'sd10630045;
  localparam logic signed [CORR_W-1:0] WINDUP_NEG      = -34'sd10630045;
  localparam logic [RATIO_W-1:0]       UNITY_Q30       = 31'd1073741824;
  localparam logic [DRIFT_W-1:0]       LARGE_DRIFT     = 24'd32000;
  localparam logic signed [SUM_W-1:0]  ROUND_HALF      = 50'sd32768;

  // drift*rate/16e6 = ((drift*rate) >> 10) / 15625
  localparam int                       PRE_SHIFT  = 10;
  localparam logic [31:0]              RECIP_M    = 32'd2251799813;
  localparam int                       RECIP_SH   = 45;
  localparam logic [13:0]              DIV_K      = 14'd15625;

  typedef enum logic [1:0] {
    ST_DEADBAND = 2'd0,
    ST_SKIP     = 2'd1,
    ST_CORRECT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_DEADBAND    = 3'd0,
    REG_MAX_COMP    = 3'd1,
    REG_PROP_GAIN   = 3'd2,
    REG_INTEG_GAIN  = 3'd3,
    REG_SAMPLE_RATE = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [22:0] deadband_threshold;
    logic [22:0] max_compensation;
    logic [23:0] prop_gain;
    logic [23:0] integral_gain;
    logic [17:0] sample_rate;
  } cfg_t;

  typedef struct packed {
    logic                      en;
    logic [DEV_IDX_W-1:0]      idx;
    logic signed [INTEG_W-1:0] data;
  } integ_wr_t;

endpackage
`default_nettype wire

// ===== design/drift_pi_resample_controller.sv =====
// Drift PI resample controller top level.
//
// Usage:
//   Input requests (in_valid/in_ready) carry a device index, its filtered
//   drift and its current delay length. Each request yields exactly one
//   result request on out_valid/out_ready with status, Q1.30 ratio and an
//   optional new delay length. Gains and thresholds sit behind an APB port.
//   Throughput: one request per cycle through the five-stage pipeline; a
//   request for a device whose previous request is still in the first four
//   stages waits until that one has written its integral.
//   A stalled receiver holds the output register; upstream stages keep
//   filling until the pipeline is full, then in_ready drops.
//   Reset restores register defaults and zeroes all integrals at once
//   through per-device valid bits; in_ready stays low while in reset.
`default_nettype none
module drift_pi_resample_controller #(
  parameter int NUM_DEVICES       = 8,
  parameter int DELAY_LINE_FRAMES = 4096
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [4:0]                           paddr,
  input  wire logic [31:0]                          pwdata,
  output logic      [31:0]                          prdata,
  output logic                                      pready,
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [dprc_pkg::DEV_W-1:0]           in_device,
  input  wire logic signed [dprc_pkg::DRIFT_W-1:0]  in_drift,
  input  wire logic [dprc_pkg::DELAY_W-1:0]         in_current_delay,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [dprc_pkg::DEV_W-1:0]                out_device_out,
  output logic [1:0]                                out_status,
  output logic [dprc_pkg::RATIO_W-1:0]              out_ratio,
  output logic                                      out_delay_update,
  output logic [dprc_pkg::DELAY_W-1:0]              out_new_delay
);

  dprc_pkg::cfg_t                       cfg;
  logic                                 st_rd_en;
  logic [dprc_pkg::DEV_IDX_W-1:0]       st_rd_idx;
  logic signed [dprc_pkg::INTEG_W-1:0]  st_rd_data;
  dprc_pkg::integ_wr_t                  st_wr;

  dprc_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dprc_integ_store #(
    .NUM_DEVICES (NUM_DEVICES)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (st_rd_en),
    .rd_idx  (st_rd_idx),
    .rd_data (st_rd_data),
    .wr      (st_wr)
  );

  dprc_datapath #(
    .NUM_DEVICES       (NUM_DEVICES),
    .DELAY_LINE_FRAMES (DELAY_LINE_FRAMES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_device        (in_device),
    .in_drift         (in_drift),
    .in_current_delay (in_current_delay),
    .st_rd_en         (st_rd_en),
    .st_rd_idx        (st_rd_idx),
    .st_rd_data       (st_rd_data),
    .st_wr            (st_wr),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_device_out   (out_device_out),
    .out_status       (out_status),
    .out_ratio        (out_ratio),
    .out_delay_update (out_delay_update),
    .out_new_delay    (out_new_delay)
  );

endmodule
`default_nettype wire

// ===== design/dprc_cfg_regs.sv =====
// APB configuration registers.
`default_nettype none
module dprc_cfg_regs (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [4:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic      [31:0]          prdata,
  output logic                      pready,
  output dprc_pkg::cfg_t            cfg
);

  dprc_pkg::cfg_t     cfg_r;
  dprc_pkg::reg_idx_t idx;
  logic               wr_en;

  assign idx    = dprc_pkg::reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband_threshold <= 23'd800;
      cfg_r.max_compensation   <= 23'd80000;
      cfg_r.prop_gain          <= 24'd8796093;
      cfg_r.integral_gain      <= 24'd43980;
      cfg_r.sample_rate        <= 18'd48000;
    end else if (wr_en) begin
      case (idx)
        dprc_pkg::REG_DEADBAND:    cfg_r.deadband_threshold <= pwdata[22:0];
        dprc_pkg::REG_MAX_COMP:    cfg_r.max_compensation   <= pwdata[22:0];
        dprc_pkg::REG_PROP_GAIN:   cfg_r.prop_gain          <= pwdata[23:0];
        dprc_pkg::REG_INTEG_GAIN:  cfg_r.integral_gain      <= pwdata[23:0];
        dprc_pkg::REG_SAMPLE_RATE: cfg_r.sample_rate        <= pwdata[17:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dprc_pkg::REG_DEADBAND:    prdata = {9'd0, cfg_r.deadband_threshold};
      dprc_pkg::REG_MAX_COMP:    prdata = {9'd0, cfg_r.max_compensation};
      dprc_pkg::REG_PROP_GAIN:   prdata = {8'd0, cfg_r.prop_gain};
      dprc_pkg::REG_INTEG_GAIN:  prdata = {8'd0, cfg_r.integral_gain};
      dprc_pkg::REG_SAMPLE_RATE: prdata = {14'd0, cfg_r.sample_rate};
      default:                   prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== design/dprc_integ_store.sv =====
// Per-device integral memory with per-entry valid bits.
`default_nettype none
module dprc_integ_store #(
  parameter int NUM_DEVICES = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   rd_en,
  input  wire logic [dprc_pkg::DEV_IDX_W-1:0]         rd_idx,
  output logic signed [dprc_pkg::INTEG_W-1:0]         rd_data,
  input  wire dprc_pkg::integ_wr_t                    wr
);

  localparam int AW = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;

  logic signed [dprc_pkg::INTEG_W-1:0] mem [NUM_DEVICES];
  logic [NUM_DEVICES-1:0]              vld_r;
  logic signed [dprc_pkg::INTEG_W-1:0] rd_q_r;
  logic                                hit_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx[AW-1:0]] <= wr.data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_idx[AW-1:0]];
      hit_r  <= vld_r[rd_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.idx[AW-1:0]] <= 1'b1;
    end
  end

  assign rd_data = hit_r ? rd_q_r : '0;

endmodule
`default_nettype wire

// ===== design/dprc_datapath.sv =====
// Five-stage PI correction pipeline with output register.
`default_nettype none
module dprc_datapath #(
  parameter int NUM_DEVICES       = 8,
  parameter int DELAY_LINE_FRAMES = 4096
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire dprc_pkg::cfg_t                         cfg,
  input  wire logic                                   in_valid,
  output logic                                        in_ready,
  input  wire logic [dprc_pkg::DEV_W-1:0]             in_device,
  input  wire logic signed [dprc_pkg::DRIFT_W-1:0]    in_drift,
  input  wire logic [dprc_pkg::DELAY_W-1:0]           in_current_delay,
  output logic                                        st_rd_en,
  output logic [dprc_pkg::DEV_IDX_W-1:0]              st_rd_idx,
  input  wire logic signed [dprc_pkg::INTEG_W-1:0]    st_rd_data,
  output dprc_pkg::integ_wr_t                         st_wr,
  output logic                                        out_valid,
  input  wire logic                                   out_ready,
  output logic [dprc_pkg::DEV_W-1:0]                  out_device_out,
  output logic [1:0]                                  out_status,
  output logic [dprc_pkg::RATIO_W-1:0]                out_ratio,
  output logic                                        out_delay_update,
  output logic [dprc_pkg::DELAY_W-1:0]                out_new_delay
);

  localparam logic [6:0] NUM_DEV_L = 7'(NUM_DEVICES);
  localparam logic signed [dprc_pkg::ND_W-1:0] ND_MAX =
    dprc_pkg::ND_W'(DELAY_LINE_FRAMES - 1);

  // handshake / flow
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en_o, hazard, acc;

  // stage 1
  logic [dprc_pkg::DEV_W-1:0]          s1_dev_r;
  logic signed [dprc_pkg::DRIFT_W-1:0] s1_drift_r;
  logic [dprc_pkg::DELAY_W-1:0]        s1_cur_r;
  logic [dprc_pkg::DRIFT_W-1:0]        drift_u1, mag1;
  logic                                in_rng1;
  dprc_pkg::status_t                   status1;
  logic signed [dprc_pkg::INTEG_W:0]   isum1;
  logic signed [dprc_pkg::INTEG_W-1:0] integ1;

  // stage 2
  logic [dprc_pkg::DEV_W-1:0]          s2_dev_r;
  dprc_pkg::status_t                   s2_status_r;
  logic signed [dprc_pkg::DRIFT_W-1:0] s2_drift_r;
  logic signed [dprc_pkg::INTEG_W-1:0] s2_integ_r;
  logic [dprc_pkg::DRIFT_W-1:0]        s2_mag_r;
  logic [dprc_pkg::DELAY_W-1:0]        s2_cur_r;
  logic                                s2_large_r;
  logic signed [24:0]                  pg_s, ig_s;
  logic signed [48:0]                  p2, q2;
  logic [41:0]                         f2;

  // stage 3
  logic [dprc_pkg::DEV_W-1:0]          s3_dev_r;
  dprc_pkg::status_t                   s3_status_r;
  logic                                s3_neg_r;
  logic signed [dprc_pkg::INTEG_W-1:0] s3_integ_r;
  logic [dprc_pkg::DELAY_W-1:0]        s3_cur_r;
  logic                                s3_large_r;
  logic signed [48:0]                  s3_p_r, s3_q_r;
  logic [31:0]                         s3_x_r;
  logic signed [dprc_pkg::SUM_W-1:0]   sum3;
  logic [63:0]                         xm3;

  // stage 4
  logic [dprc_pkg::DEV_W-1:0]          s4_dev_r;
  dprc_pkg::status_t                   s4_status_r;
  logic                                s4_neg_r;
  logic signed [dprc_pkg::INTEG_W-1:0] s4_integ_r;
  logic [dprc_pkg::DELAY_W-1:0]        s4_cur_r;
  logic                                s4_large_r;
  logic signed [dprc_pkg::SUM_W-1:0]   s4_sum_r;
  logic [31:0]                         s4_x_r;
  logic [dprc_pkg::FRAMES_W-1:0]       s4_qe_r;
  logic signed [dprc_pkg::CORR_W-1:0]  c4, ccl4;
  logic                                windup4;
  logic signed [dprc_pkg::INTEG_W-1:0] integ_new4;
  logic [dprc_pkg::RATIO_W-1:0]        ratio4;
  logic [32:0]                         prod4;

  // stage 5
  logic [dprc_pkg::DEV_W-1:0]          s5_dev_r;
  dprc_pkg::status_t                   s5_status_r;
  logic                                s5_neg_r;
  logic [dprc_pkg::DELAY_W-1:0]        s5_cur_r;
  logic                                s5_large_r;
  logic [dprc_pkg::RATIO_W-1:0]        s5_ratio_r;
  logic [31:0]                         s5_x_r;
  logic [dprc_pkg::FRAMES_W-1:0]       s5_qe_r;
  logic [32:0]                         s5_prod_r;
  logic [dprc_pkg::FRAMES_W-1:0]       fr5;
  logic signed [dprc_pkg::ND_W-1:0]    cur5, frs5, nd5, ndc5;
  logic                                upd5;

  // output register
  logic [dprc_pkg::DEV_W-1:0]          o_dev_r;
  logic [1:0]                          o_status_r;
  logic [dprc_pkg::RATIO_W-1:0]        o_ratio_r;
  logic                                o_upd_r;
  logic [dprc_pkg::DELAY_W-1:0]        o_nd_r;

  // flow control: a stage moves when the next one is empty or moving
  always_comb begin
    en_o   = !out_valid_r || out_ready;
    en5    = !v5_r || en_o;
    en4    = !v4_r || en5;
    en3    = !v3_r || en4;
    en2    = !v2_r || en3;
    en1    = !v1_r || en2;
    // same device still in flight before its integral write
    hazard = (v1_r && (s1_dev_r == in_device)) ||
             (v2_r && (s2_dev_r == in_device)) ||
             (v3_r && (s3_dev_r == in_device)) ||
             (v4_r && (s4_dev_r == in_device));
    in_ready = en1 && !hazard && rst_n;
    acc      = in_valid && in_ready;
  end

  assign st_rd_en  = acc;
  assign st_rd_idx = {3'd0, in_device};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= acc;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en_o) out_valid_r <= v5_r;
    end
  end

  // stage 1: classify, accumulate and clamp integral
  always_comb begin
    drift_u1 = s1_drift_r;
    mag1     = drift_u1[dprc_pkg::DRIFT_W-1] ? (~drift_u1 + 24'd1) : drift_u1;
    in_rng1  = ({4'd0, s1_dev_r} < NUM_DEV_L);
    if (!in_rng1) begin
      status1 = dprc_pkg::ST_SKIP;
    end else if (mag1 < {1'b0, cfg.deadband_threshold}) begin
      status1 = dprc_pkg::ST_DEADBAND;
    end else if (mag1 > {1'b0, cfg.max_compensation}) begin
      status1 = dprc_pkg::ST_SKIP;
    end else begin
      status1 = dprc_pkg::ST_CORRECT;
    end
    isum1 = {st_rd_data[dprc_pkg::INTEG_W-1], st_rd_data} +
            {s1_drift_r[dprc_pkg::DRIFT_W-1], s1_drift_r};
    if (isum1 > dprc_pkg::INTEG_LIMIT) begin
      integ1 = dprc_pkg::INTEG_W'(dprc_pkg::INTEG_LIMIT);
    end else if (isum1 < dprc_pkg::INTEG_LIMIT_NEG) begin
      integ1 = dprc_pkg::INTEG_W'(dprc_pkg::INTEG_LIMIT_NEG);
    end else begin
      integ1 = isum1[dprc_pkg::INTEG_W-1:0];
    end
  end

  // stage 2: products
  always_comb begin
    pg_s = {1'b0, cfg.prop_gain};
    ig_s = {1'b0, cfg.integral_gain};
    p2   = pg_s * s2_drift_r;
    q2   = ig_s * s2_integ_r;
    f2   = s2_mag_r * cfg.sample_rate;
  end

  // stage 3: correction sum and reciprocal product
  always_comb begin
    sum3 = dprc_pkg::SUM_W'(s3_p_r) + dprc_pkg::SUM_W'(s3_q_r) + dprc_pkg::ROUND_HALF;
    xm3  = s3_x_r * dprc_pkg::RECIP_M;
  end

  // stage 4: ratio clamp, anti-windup, quotient check product
  always_comb begin
    c4 = $signed(s4_sum_r[dprc_pkg::SUM_W-1:16]);
    if (c4 > dprc_pkg::CORR_MAX) begin
      ccl4 = dprc_pkg::CORR_MAX;
    end else if (c4 < dprc_pkg::CORR_MIN) begin
      ccl4 = dprc_pkg::CORR_MIN;
    end else begin
      ccl4 = c4;
    end
    ratio4     = dprc_pkg::UNITY_Q30 + ccl4[dprc_pkg::RATIO_W-1:0];
    windup4    = (ccl4 >= dprc_pkg::WINDUP_POS) || (ccl4 <= dprc_pkg::WINDUP_NEG);
    integ_new4 = windup4 ? (s4_integ_r >>> 1) : s4_integ_r;
    prod4      = s4_qe_r * dprc_pkg::DIV_K;
    st_wr.en   = v4_r && en5 && (s4_status_r != dprc_pkg::ST_SKIP);
    st_wr.idx  = {3'd0, s4_dev_r};
    st_wr.data = (s4_status_r == dprc_pkg::ST_DEADBAND) ? '0 : integ_new4;
  end

  // stage 5: frame count and new delay
  always_comb begin
    fr5 = s5_qe_r;
    if ({2'b00, s5_x_r} >= ({1'b0, s5_prod_r} + {20'd0, dprc_pkg::DIV_K})) begin
      fr5 = s5_qe_r + 19'd1;
    end
    cur5 = {9'd0, s5_cur_r};
    frs5 = {2'd0, fr5};
    nd5  = s5_neg_r ? (cur5 + frs5) : (cur5 - frs5);
    if (nd5 < 0) begin
      ndc5 = '0;
    end else if (nd5 > ND_MAX) begin
      ndc5 = ND_MAX;
    end else begin
      ndc5 = nd5;
    end
    upd5 = (s5_status_r == dprc_pkg::ST_CORRECT) && s5_large_r;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_dev_r   <= in_device;
      s1_drift_r <= in_drift;
      s1_cur_r   <= in_current_delay;
    end
    if (en2) begin
      s2_dev_r    <= s1_dev_r;
      s2_status_r <= status1;
      s2_drift_r  <= s1_drift_r;
      s2_integ_r  <= integ1;
      s2_mag_r    <= mag1;
      s2_cur_r    <= s1_cur_r;
      s2_large_r  <= (mag1 > dprc_pkg::LARGE_DRIFT);
    end
    if (en3) begin
      s3_dev_r    <= s2_dev_r;
      s3_status_r <= s2_status_r;
      s3_neg_r    <= s2_drift_r[dprc_pkg::DRIFT_W-1];
      s3_integ_r  <= s2_integ_r;
      s3_cur_r    <= s2_cur_r;
      s3_large_r  <= s2_large_r;
      s3_p_r      <= p2;
      s3_q_r      <= q2;
      s3_x_r      <= f2[41:dprc_pkg::PRE_SHIFT];
    end
    if (en4) begin
      s4_dev_r    <= s3_dev_r;
      s4_status_r <= s3_status_r;
      s4_neg_r    <= s3_neg_r;
      s4_integ_r  <= s3_integ_r;
      s4_cur_r    <= s3_cur_r;
      s4_large_r  <= s3_large_r;
      s4_sum_r    <= sum3;
      s4_x_r      <= s3_x_r;
      s4_qe_r     <= xm3[63:dprc_pkg::RECIP_SH];
    end
    if (en5) begin
      s5_dev_r    <= s4_dev_r;
      s5_status_r <= s4_status_r;
      s5_neg_r    <= s4_neg_r;
      s5_cur_r    <= s4_cur_r;
      s5_large_r  <= s4_large_r;
      s5_ratio_r  <= ratio4;
      s5_x_r      <= s4_x_r;
      s5_qe_r     <= s4_qe_r;
      s5_prod_r   <= prod4;
    end
    if (en_o) begin
      o_dev_r    <= s5_dev_r;
      o_status_r <= s5_status_r;
      o_ratio_r  <= (s5_status_r == dprc_pkg::ST_CORRECT) ? s5_ratio_r : '0;
      o_upd_r    <= upd5;
      o_nd_r     <= upd5 ? ndc5[dprc_pkg::DELAY_W-1:0] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_device_out   = o_dev_r;
  assign out_status       = o_status_r;
  assign out_ratio        = o_ratio_r;
  assign out_delay_update = o_upd_r;
  assign out_new_delay    = o_nd_r;

endmodule
`default_nettype wire

// ===== verif/drift_pi_resample_controller_test.sv =====
// Self-checking testbench for the drift PI resample controller: directed table, random phases.
`timescale 1ns / 1ps
module drift_pi_resample_controller_test;

  localparam int     NUM_DEV      = 8;
  localparam int     LINE_FRAMES  = 4096;
  localparam longint Q30_ONE      = 1073741824;
  localparam longint RATIO_LO     = 1063004405;
  localparam longint RATIO_HI     = 1084479242;
  localparam longint WINDUP_OFFS  = 10630045;
  localparam longint INTEG_CLAMP  = 8000000;
  localparam longint BIG_DRIFT    = 32000;
  localparam longint US16_PER_SEC = 16000000;
  localparam longint DRIFT_SPAN   = 8388608;
  localparam int     HOLD_CYCLES  = 300;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam int     DIR_ROWS     = 23;

  typedef struct packed {
    logic [dprc_pkg::DEV_W-1:0]   device;
    logic [1:0]                   status;
    logic [dprc_pkg::RATIO_W-1:0] ratio;
    logic                         delay_update;
    logic [dprc_pkg::DELAY_W-1:0] new_delay;
  } resample_res_t;

  typedef struct packed {
    logic [dprc_pkg::DEV_W-1:0]          device;
    logic signed [dprc_pkg::DRIFT_W-1:0] drift;
    logic [dprc_pkg::DELAY_W-1:0]        delay;
    logic                                fixed_exp;
    dprc_pkg::status_t                   status;
  } drift_row_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic                                psel = 1'b0;
  logic                                penable = 1'b0;
  logic                                pwrite = 1'b0;
  logic [4:0]                          paddr = '0;
  logic [31:0]                         pwdata = '0;
  wire  [31:0]                         prdata;
  wire                                 pready;
  logic                                in_valid = 1'b0;
  wire                                 in_ready;
  logic [dprc_pkg::DEV_W-1:0]          in_device = '0;
  logic signed [dprc_pkg::DRIFT_W-1:0] in_drift = '0;
  logic [dprc_pkg::DELAY_W-1:0]        in_current_delay = '0;
  wire                                 out_valid;
  logic                                out_ready = 1'b0;
  wire  [dprc_pkg::DEV_W-1:0]          out_device_out;
  wire  [1:0]                          out_status;
  wire  [dprc_pkg::RATIO_W-1:0]        out_ratio;
  wire                                 out_delay_update;
  wire  [dprc_pkg::DELAY_W-1:0]        out_new_delay;

  longint cfg_deadband = 800;
  longint cfg_max_comp = 80000;
  longint cfg_prop_gain = 8796093;
  longint cfg_integ_gain = 43980;
  longint cfg_rate = 48000;
  longint integ_mirror [NUM_DEV];

  resample_res_t              pending_results [$];
  int                         mismatches = 0;
  int                         cycles = 0;
  int                         send_idle = 0;
  int                         recv_idle = 0;
  int                         hold_asked = 0;
  int                         hold_taken = 0;
  int                         hold_left = 0;
  logic [dprc_pkg::DEV_W-1:0] last_dev = '0;

  // after reset, fixed expectations only for deadband and skip rows
  drift_row_t drift_rows [DIR_ROWS] = '{
    '{3'd0, 24'sd0,        12'd0,    1'b1, dprc_pkg::ST_DEADBAND},
    '{3'd7, 24'sd799,      12'd4095, 1'b1, dprc_pkg::ST_DEADBAND},
    '{3'd1, -24'sd799,     12'd4095, 1'b1, dprc_pkg::ST_DEADBAND},
    '{3'd4, 24'sd80001,    12'd100,  1'b1, dprc_pkg::ST_SKIP},
    '{3'd5, -24'sd8388608, 12'd0,    1'b1, dprc_pkg::ST_SKIP},
    '{3'd6, 24'sd8388607,  12'd4095, 1'b1, dprc_pkg::ST_SKIP},
    '{3'd6, -24'sd80001,   12'd7,    1'b1, dprc_pkg::ST_SKIP},
    '{3'd2, 24'sd800,      12'd0,    1'b0, dprc_pkg::ST_CORRECT},
    '{3'd2, -24'sd800,     12'd1,    1'b0, dprc_pkg::ST_CORRECT},
    '{3'd3, 24'sd32000,    12'd2048, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd3, 24'sd32001,    12'd2048, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd3, -24'sd32001,   12'd2048, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd1, 24'sd80000,    12'd0,    1'b0, dprc_pkg::ST_CORRECT},
    '{3'd1, 24'sd80000,    12'd0,    1'b0, dprc_pkg::ST_CORRECT},
    '{3'd1, 24'sd80000,    12'd0,    1'b0, dprc_pkg::ST_CORRECT},
    '{3'd1, -24'sd80000,   12'd4095, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd1, -24'sd80000,   12'd4095, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd1, 24'sd400,      12'd5,    1'b1, dprc_pkg::ST_DEADBAND},
    '{3'd1, 24'sd5000,     12'd1234, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd0, -24'sd12345,   12'd2222, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd7, 24'sd79999,    12'd4095, 1'b0, dprc_pkg::ST_CORRECT},
    '{3'd4, -24'sd40000,   12'd10,   1'b0, dprc_pkg::ST_CORRECT},
    '{3'd2, 24'sd80000,    12'd4095, 1'b0, dprc_pkg::ST_CORRECT}
  };

  drift_pi_resample_controller #(
    .NUM_DEVICES      (NUM_DEV),
    .DELAY_LINE_FRAMES(LINE_FRAMES)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_device       (in_device),
    .in_drift        (in_drift),
    .in_current_delay(in_current_delay),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_device_out  (out_device_out),
    .out_status      (out_status),
    .out_ratio       (out_ratio),
    .out_delay_update(out_delay_update),
    .out_new_delay   (out_new_delay)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic resample_res_t resample_predict(
      logic [dprc_pkg::DEV_W-1:0] dev,
      logic signed [dprc_pkg::DRIFT_W-1:0] drift,
      logic [dprc_pkg::DELAY_W-1:0] delay);
    longint d, mag, cur, acc, ratio, offs, fr, nd;
    resample_res_t r;
    d = drift;
    cur = delay;
    mag = (d < 0) ? -d : d;
    r = '0;
    r.device = dev;
    r.status = dprc_pkg::ST_SKIP;
    if (mag < cfg_deadband) begin
      integ_mirror[dev] = 0;
      r.status = dprc_pkg::ST_DEADBAND;
    end else if (mag <= cfg_max_comp) begin
      r.status = dprc_pkg::ST_CORRECT;
      acc = integ_mirror[dev] + d;
      if (acc > INTEG_CLAMP) acc = INTEG_CLAMP;
      if (acc < -INTEG_CLAMP) acc = -INTEG_CLAMP;
      ratio = Q30_ONE + ((cfg_prop_gain * d + cfg_integ_gain * acc + 32768) >>> 16);
      if (ratio < RATIO_LO) ratio = RATIO_LO;
      if (ratio > RATIO_HI) ratio = RATIO_HI;
      offs = ratio - Q30_ONE;
      if (offs < 0) offs = -offs;
      // anti-windup: a ratio offset at or past the windup threshold halves the stored integral
      if (offs >= WINDUP_OFFS) acc = acc >>> 1;
      integ_mirror[dev] = acc;
      r.ratio = ratio[dprc_pkg::RATIO_W-1:0];
      if (mag > BIG_DRIFT) begin
        fr = (mag * cfg_rate) / US16_PER_SEC;
        nd = (d < 0) ? cur + fr : cur - fr;
        if (nd < 0) nd = 0;
        if (nd > LINE_FRAMES - 1) nd = LINE_FRAMES - 1;
        r.delay_update = 1'b1;
        r.new_delay = nd[dprc_pkg::DELAY_W-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic signed [dprc_pkg::DRIFT_W-1:0] pick_drift();
    longint m, v;
    m = 0;
    case ($urandom_range(0, 15))
      0, 15: m = $urandom_range(0, DRIFT_SPAN);
      1, 2: if (cfg_deadband > 0) m = $urandom_range(0, cfg_deadband - 1);
      13: m = (cfg_max_comp < DRIFT_SPAN) ? $urandom_range(cfg_max_comp + 1, DRIFT_SPAN)
                                          : DRIFT_SPAN;
      14: begin
        case ($urandom_range(0, 7))
          0: m = cfg_deadband;
          1: m = cfg_deadband - 1;
          2: m = cfg_max_comp;
          3: m = cfg_max_comp + 1;
          4: m = BIG_DRIFT;
          5: m = BIG_DRIFT + 1;
          6: m = DRIFT_SPAN - 1;
          default: m = DRIFT_SPAN;
        endcase
      end
      default: begin
        if (cfg_deadband <= cfg_max_comp) m = $urandom_range(cfg_deadband, cfg_max_comp);
        else m = $urandom_range(0, DRIFT_SPAN);
      end
    endcase
    if (m < 0) m = 0;
    v = (m == DRIFT_SPAN || $urandom_range(0, 1) == 1) ? -m : m;
    return v[dprc_pkg::DRIFT_W-1:0];
  endfunction

  task automatic take_result();
    resample_res_t got, want;
    got = {out_device_out, out_status, out_ratio, out_delay_update, out_new_delay};
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: dev=%0d st=%0d ratio=%0d upd=%0d nd=%0d",
                 got.device, got.status, got.ratio, got.delay_update, got.new_delay);
    end else begin
      want = pending_results.pop_front();
      if (got.device !== want.device || got.status !== want.status ||
          got.ratio !== want.ratio || got.delay_update !== want.delay_update ||
          got.new_delay !== want.new_delay) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp dev=%0d st=%0d ratio=%0d upd=%0d nd=%0d / got dev=%0d st=%0d ratio=%0d upd=%0d nd=%0d",
                   want.device, want.status, want.ratio, want.delay_update, want.new_delay,
                   got.device, got.status, got.ratio, got.delay_update, got.new_delay);
      end
    end
  endtask

  // result side: checker, random back-pressure and long hold-offs
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) take_result();
    if (hold_taken != hold_asked) begin
      hold_taken <= hold_asked;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  task automatic send_drift(input logic [dprc_pkg::DEV_W-1:0] dev,
                            input logic signed [dprc_pkg::DRIFT_W-1:0] drift,
                            input logic [dprc_pkg::DELAY_W-1:0] delay,
                            input logic fixed_exp,
                            input dprc_pkg::status_t fixed_status);
    resample_res_t want;
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_device <= dev;
    in_drift <= drift;
    in_current_delay <= delay;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    want = resample_predict(dev, drift, delay);
    if (fixed_exp) begin
      want = '0;
      want.device = dev;
      want.status = fixed_status;
    end
    pending_results.push_back(want);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] idx, input longint value);
    logic [31:0] rd, want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value[31:0];
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    want = '0;
    case (idx)
      dprc_pkg::REG_DEADBAND: begin
        cfg_deadband = value[22:0];
        want = cfg_deadband[31:0];
      end
      dprc_pkg::REG_MAX_COMP: begin
        cfg_max_comp = value[22:0];
        want = cfg_max_comp[31:0];
      end
      dprc_pkg::REG_PROP_GAIN: begin
        cfg_prop_gain = value[23:0];
        want = cfg_prop_gain[31:0];
      end
      dprc_pkg::REG_INTEG_GAIN: begin
        cfg_integ_gain = value[23:0];
        want = cfg_integ_gain[31:0];
      end
      dprc_pkg::REG_SAMPLE_RATE: begin
        cfg_rate = value[17:0];
        want = cfg_rate[31:0];
      end
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (idx <= dprc_pkg::REG_SAMPLE_RATE && rd !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("readback mismatch: reg %0d exp %0d got %0d", idx, want, rd);
    end
  endtask

  task automatic run_phase(input longint db, input longint mc, input longint pg,
                           input longint ig, input longint sr, input int items,
                           input int s_idle, input int r_idle, input bit squeeze);
    logic [dprc_pkg::DEV_W-1:0]   dev;
    logic [dprc_pkg::DELAY_W-1:0] delay;
    apb_write(dprc_pkg::REG_DEADBAND, db);
    apb_write(dprc_pkg::REG_MAX_COMP, mc);
    apb_write(dprc_pkg::REG_PROP_GAIN, pg);
    apb_write(dprc_pkg::REG_INTEG_GAIN, ig);
    apb_write(dprc_pkg::REG_SAMPLE_RATE, sr);
    send_idle = s_idle;
    recv_idle <= r_idle;
    if (squeeze) hold_asked <= hold_asked + 1;
    for (int i = 0; i < items; i++) begin
      // back-to-back requests on one device exercise the integral hazard
      dev = ($urandom_range(0, 1) == 1) ? last_dev
                                        : dprc_pkg::DEV_W'($urandom_range(0, NUM_DEV - 1));
      case ($urandom_range(0, 7))
        0: delay = '0;
        1: delay = '1;
        default: delay = dprc_pkg::DELAY_W'($urandom_range(0, LINE_FRAMES - 1));
      endcase
      send_drift(dev, pick_drift(), delay, 1'b0, dprc_pkg::ST_SKIP);
      last_dev = dev;
    end
    drain();
  endtask

  initial begin
    foreach (integ_mirror[i]) integ_mirror[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle = 34;
    recv_idle <= 79;
    for (int i = 0; i < DIR_ROWS; i++)
      send_drift(drift_rows[i].device, drift_rows[i].drift, drift_rows[i].delay,
                 drift_rows[i].fixed_exp, drift_rows[i].status);
    drain();

    run_phase(800, 80000, 8796093, 43980, 48000, 200, 34, 79, 1'b0);
    run_phase(0, 8388607, 16777215, 16777215, 262143, 200, 34, 79, 1'b0);
    // writes to unmapped indices must leave the registers alone
    for (int k = dprc_pkg::REG_SAMPLE_RATE + 1; k < 8; k++) apb_write(k[2:0], $urandom);
    // deadband above range, zero gains and zero rate
    run_phase(8388607, 0, 0, 0, 0, 80, 34, 79, 1'b0);
    // tiny integral gain lets the integral run into its clamp
    run_phase(1, 8388607, 0, 1, 8000, 200, 79, 34, 1'b1);
    run_phase($urandom_range(0, 4000), $urandom_range(40000, 8388607),
              $urandom_range(0, 16777215), $urandom_range(0, 16777215),
              $urandom_range(8000, 192000), 200, 79, 34, 1'b0);
    run_phase($urandom_range(0, 8388607), $urandom_range(0, 8388607),
              $urandom_range(0, 16777215), $urandom_range(0, 16777215),
              $urandom_range(0, 262143), 200, 79, 34, 1'b0);
    run_phase(0, 8388607, $urandom_range(0, 16777215), $urandom_range(0, 65535),
              192000, 200, 0, 0, 1'b1);
    run_phase($urandom_range(0, 2000), $urandom_range(32000, 200000),
              $urandom_range(0, 16777215), $urandom_range(0, 200000),
              $urandom_range(8000, 192000), 200, 0, 0, 1'b0);
    run_phase(800, 80000, 8796093, 43980, 48000, 300, 0, 0, 1'b0);

    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule
